// File: hdl/packed_float_stream_decoder_top_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef PACKED_FLOAT_STREAM_DECODER_TOP_MACROS_SVH
`define PACKED_FLOAT_STREAM_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pfsd_pkg.sv
package pfsd_pkg;

    localparam int CODE_W        = 32;
    localparam int STORE_W       = 40;
    localparam int COUNT_W       = 20;
    localparam int MAX_CODE_BITS = 32;
    localparam int STEP_RESULTS  = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMAT_MODE    = 3'd0,
        CFG_CODE_BITS      = 3'd1,
        CFG_RANGE_EXPONENT = 3'd2,
        CFG_MINIMUM_VALUE  = 3'd3,
        CFG_VALUE_COUNT    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_CVT_LZ,
        ST_CVT,
        ST_MUL,
        ST_ALIGN,
        ST_ADD,
        ST_NORM_LZ,
        ST_NORM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_record;
    } in_t;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_of_run;
        logic        record_done;
    } out_t;

    // Count of leading zeros of a 32-bit word; 32 for an all-zero word.
    function automatic logic [5:0] lzc32(input logic [31:0] x);
        logic [5:0] n;
        logic       seen;
        n    = 6'd0;
        seen = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!seen && !x[i])
            begin
                n = n + 6'd1;
            end
            else
            begin
                seen = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

// File: hdl/packed_float_stream_decoder_top.sv
// Channel  | Signals                         | Beat
// ---------+---------------------------------+------------------------------------
// input    | in_valid, in_ready, in_data     | one payload byte, record start flag
// output   | out_valid, out_ready, out_data  | one IEEE single value and flags
// config   | cfg_write, cfg_index, cfg_data  | one register write, no wait
//
// Each value that a byte completes goes from EXTRACT to OUT, in packed mode through
// convert to normalize states. A single sequencer and one shared leading-zero counter
// carry each packed-mode value through convert, scale, align, add and round. Reset is
// asynchronous and active low and clears the bit store and the count of values left.
// The block takes no new byte until every value of the current byte has been taken.
module packed_float_stream_decoder_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  pfsd_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output pfsd_pkg::out_t                     out_data,
    input  logic                               cfg_write,
    input  logic [pfsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pfsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pfsd_pkg::state_t state_reg, state_next;

    logic                             fmt_reg;
    logic [5:0]                       cbits_reg;
    logic signed [8:0]                rexp_reg;
    logic [31:0]                      min_reg;
    logic [pfsd_pkg::COUNT_W-1:0]     vcount_reg;

    logic [pfsd_pkg::STORE_W-1:0]     store_reg, store_next;
    logic [5:0]                       held_reg, held_next;
    logic [pfsd_pkg::COUNT_W-1:0]     left_reg, left_next;
    logic [3:0]                       count_reg, count_next;
    logic [pfsd_pkg::CODE_W-1:0]      code_reg, code_next;
    logic                             last_reg, last_next;
    logic                             done_reg, done_next;
    logic [5:0]                       lz_reg, lz_next;
    logic [23:0]                      m_reg, m_next;
    logic [5:0]                       p_reg, p_next;
    logic [31:0]                      prod_reg, prod_next;
    logic                             spec_reg, spec_next;
    logic [31:0]                      spec_bits_reg, spec_bits_next;
    logic [8:0]                       exp_reg, exp_next;
    logic                             sign_reg, sign_next;
    logic                             sub_reg, sub_next;
    logic [26:0]                      ma_reg, ma_next;
    logic [26:0]                      mb_reg, mb_next;
    logic [27:0]                      sum_reg, sum_next;
    pfsd_pkg::out_t                   out_reg, out_next;

    logic [5:0]  n_eff;
    logic        can_take;
    logic [5:0]  ex_sh;
    logic [31:0] lz_in;
    logic [5:0]  lz_out;

    assign in_ready  = (state_reg == pfsd_pkg::ST_IDLE);
    assign out_valid = (state_reg == pfsd_pkg::ST_OUT);
    assign out_data  = out_reg;

    always_comb
    begin
        if (fmt_reg)
        begin
            n_eff = 6'd32;
        end
        else if (cbits_reg == 6'd0)
        begin
            n_eff = 6'd1;
        end
        else if (cbits_reg > 6'(pfsd_pkg::MAX_CODE_BITS))
        begin
            n_eff = 6'(pfsd_pkg::MAX_CODE_BITS);
        end
        else
        begin
            n_eff = cbits_reg;
        end
        can_take = (count_reg < 4'(pfsd_pkg::STEP_RESULTS)) && (left_reg != '0)
                   && (held_reg >= n_eff);
        ex_sh    = held_reg - n_eff;
    end

    // The one leading-zero counter serves both the code convert and the sum normalize.
    assign lz_in  = (state_reg == pfsd_pkg::ST_CVT_LZ) ? code_reg : {sum_reg[26:0], 5'b11111};
    assign lz_out = pfsd_pkg::lzc32(lz_in);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfsd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pfsd_pkg::ST_EXTRACT;
                end
            end
            pfsd_pkg::ST_EXTRACT:
            begin
                if (!can_take)
                begin
                    state_next = pfsd_pkg::ST_IDLE;
                end
                else if (fmt_reg)
                begin
                    state_next = pfsd_pkg::ST_OUT;
                end
                else
                begin
                    state_next = pfsd_pkg::ST_CVT_LZ;
                end
            end
            pfsd_pkg::ST_CVT_LZ:  state_next = pfsd_pkg::ST_CVT;
            pfsd_pkg::ST_CVT:     state_next = pfsd_pkg::ST_MUL;
            pfsd_pkg::ST_MUL:     state_next = pfsd_pkg::ST_ALIGN;
            pfsd_pkg::ST_ALIGN:   state_next = pfsd_pkg::ST_ADD;
            pfsd_pkg::ST_ADD:     state_next = pfsd_pkg::ST_NORM_LZ;
            pfsd_pkg::ST_NORM_LZ: state_next = pfsd_pkg::ST_NORM;
            pfsd_pkg::ST_NORM:    state_next = pfsd_pkg::ST_OUT;
            pfsd_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = pfsd_pkg::ST_EXTRACT;
                end
            end
            default:              state_next = pfsd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        logic [pfsd_pkg::COUNT_W-1:0] left1;
        logic [pfsd_pkg::STORE_W-1:0] store1;
        logic [5:0]                   held1;
        logic [pfsd_pkg::COUNT_W-1:0] left_dec;
        logic [31:0]                  nrm;
        logic [24:0]                  m1;
        logic                         inc;
        logic signed [9:0]            t;
        logic signed [9:0]            biased;
        logic signed [9:0]            kk;
        logic [47:0]                  xs;
        logic [24:0]                  f;
        logic [7:0]                   ea_f;
        logic [7:0]                   eb_f;
        logic                         a_nan;
        logic                         b_nan;
        logic                         a_inf;
        logic                         b_inf;
        logic [7:0]                   ea;
        logic [7:0]                   eb;
        logic [26:0]                  mxa;
        logic [26:0]                  mxb;
        logic                         a_big;
        logic [7:0]                   d;
        logic [26:0]                  msml;
        logic [26:0]                  smask;
        logic [26:0]                  mn;
        logic [8:0]                   e1;
        logic [5:0]                   lim;
        logic [5:0]                   sh;
        logic [24:0]                  k;
        logic [23:0]                  km;

        left1    = '0;
        store1   = '0;
        held1    = '0;
        left_dec = '0;
        nrm      = '0;
        m1       = '0;
        inc      = 1'b0;
        t        = '0;
        biased   = '0;
        kk       = '0;
        xs       = '0;
        f        = '0;
        ea_f     = '0;
        eb_f     = '0;
        a_nan    = 1'b0;
        b_nan    = 1'b0;
        a_inf    = 1'b0;
        b_inf    = 1'b0;
        ea       = '0;
        eb       = '0;
        mxa      = '0;
        mxb      = '0;
        a_big    = 1'b0;
        d        = '0;
        msml     = '0;
        smask    = '0;
        mn       = '0;
        e1       = '0;
        lim      = '0;
        sh       = '0;
        k        = '0;
        km       = '0;

        store_next     = store_reg;
        held_next      = held_reg;
        left_next      = left_reg;
        count_next     = count_reg;
        code_next      = code_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        lz_next        = lz_reg;
        m_next         = m_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        spec_next      = spec_reg;
        spec_bits_next = spec_bits_reg;
        exp_next       = exp_reg;
        sign_next      = sign_reg;
        sub_next       = sub_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;

        case (state_reg)
            pfsd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    left1  = in_data.first_of_record ? vcount_reg : left_reg;
                    store1 = in_data.first_of_record ? '0 : store_reg;
                    held1  = in_data.first_of_record ? 6'd0 : held_reg;
                    count_next = 4'd0;
                    left_next  = left1;
                    if (left1 == '0)
                    begin
                        store_next = '0;
                        held_next  = 6'd0;
                    end
                    else
                    begin
                        store_next = {store1[pfsd_pkg::STORE_W-9:0], in_data.data_byte};
                        held_next  = held1 + 6'd8;
                    end
                end
            end
            pfsd_pkg::ST_EXTRACT:
            begin
                if (can_take)
                begin
                    left_dec   = left_reg - 1'b1;
                    code_next  = 32'((store_reg >> ex_sh)
                                     & ((40'd1 << n_eff) - 40'd1));
                    count_next = count_reg + 4'd1;
                    left_next  = left_dec;
                    done_next  = (left_dec == '0);
                    last_next  = !(((count_reg + 4'd1) < 4'(pfsd_pkg::STEP_RESULTS))
                                   && (left_dec != '0) && (ex_sh >= n_eff));
                    if (left_dec == '0)
                    begin
                        store_next = '0;
                        held_next  = 6'd0;
                    end
                    else
                    begin
                        store_next = store_reg & ((40'd1 << ex_sh) - 40'd1);
                        held_next  = ex_sh;
                    end
                    out_next.value_bits  = 32'((store_reg >> ex_sh)
                                               & ((40'd1 << n_eff) - 40'd1));
                    out_next.last_of_run = !(((count_reg + 4'd1) < 4'(pfsd_pkg::STEP_RESULTS))
                                             && (left_dec != '0) && (ex_sh >= n_eff));
                    out_next.record_done = (left_dec == '0);
                end
                else if (left_reg == '0)
                begin
                    store_next = '0;
                    held_next  = 6'd0;
                end
            end
            pfsd_pkg::ST_CVT_LZ:
            begin
                lz_next = lz_out;
            end
            pfsd_pkg::ST_CVT:
            begin
                // Round the integer code to a 24-bit significand, nearest even.
                nrm = code_reg << lz_reg;
                inc = nrm[7] & ((|nrm[6:0]) | nrm[8]);
                m1  = {1'b0, nrm[31:8]} + 25'(inc);
                if (m1[24])
                begin
                    m_next = m1[24:1];
                    p_next = 6'd32 - lz_reg;
                end
                else
                begin
                    m_next = m1[23:0];
                    p_next = 6'd31 - lz_reg;
                end
            end
            pfsd_pkg::ST_MUL:
            begin
                // Scaling by a power of two only moves the exponent, except when the
                // product falls into the subnormal range and must be rounded again.
                t      = $signed({4'b0000, p_reg}) + 10'(rexp_reg);
                biased = t + 10'sd127;
                if (code_reg == '0)
                begin
                    prod_next = (rexp_reg > 9'sd127) ? pfsd_pkg::QNAN_BITS : 32'h0;
                end
                else if (rexp_reg > 9'sd127)
                begin
                    prod_next = 32'h7F80_0000;
                end
                else if (rexp_reg < -9'sd149)
                begin
                    prod_next = 32'h0;
                end
                else if (biased >= 10'sd255)
                begin
                    prod_next = 32'h7F80_0000;
                end
                else if (biased >= 10'sd1)
                begin
                    prod_next = {1'b0, biased[7:0], m_reg[22:0]};
                end
                else
                begin
                    kk        = 10'sd0 - (t + 10'sd126);
                    xs        = {m_reg, 24'h0} >> kk[4:0];
                    inc       = xs[23] & ((|xs[22:0]) | xs[24]);
                    f         = {1'b0, xs[47:24]} + 25'(inc);
                    prod_next = 32'(f);
                end
            end
            pfsd_pkg::ST_ALIGN:
            begin
                ea_f  = prod_reg[30:23];
                eb_f  = min_reg[30:23];
                a_nan = (&ea_f) && (prod_reg[22:0] != '0);
                b_nan = (&eb_f) && (min_reg[22:0] != '0);
                a_inf = (&ea_f) && (prod_reg[22:0] == '0);
                b_inf = (&eb_f) && (min_reg[22:0] == '0);
                spec_next = a_nan || b_nan || a_inf || b_inf;
                if (a_nan || b_nan || (a_inf && b_inf && (prod_reg[31] != min_reg[31])))
                begin
                    spec_bits_next = pfsd_pkg::QNAN_BITS;
                end
                else if (a_inf)
                begin
                    spec_bits_next = prod_reg;
                end
                else
                begin
                    spec_bits_next = min_reg;
                end
                ea    = (ea_f == 8'd0) ? 8'd1 : ea_f;
                eb    = (eb_f == 8'd0) ? 8'd1 : eb_f;
                mxa   = {(ea_f != 8'd0), prod_reg[22:0], 3'b000};
                mxb   = {(eb_f != 8'd0), min_reg[22:0], 3'b000};
                a_big = (prod_reg[30:0] >= min_reg[30:0]);
                d     = a_big ? (ea - eb) : (eb - ea);
                msml  = a_big ? mxb : mxa;
                if (d >= 8'd27)
                begin
                    mb_next = {26'h0, (msml != '0)};
                end
                else
                begin
                    smask   = ~(27'h7FF_FFFF << d[4:0]);
                    mb_next = (msml >> d[4:0]) | {26'h0, ((msml & smask) != '0)};
                end
                ma_next   = a_big ? mxa : mxb;
                exp_next  = {1'b0, (a_big ? ea : eb)};
                sign_next = a_big ? prod_reg[31] : min_reg[31];
                sub_next  = prod_reg[31] ^ min_reg[31];
            end
            pfsd_pkg::ST_ADD:
            begin
                sum_next = sub_reg ? ({1'b0, ma_reg} - {1'b0, mb_reg})
                                   : ({1'b0, ma_reg} + {1'b0, mb_reg});
            end
            pfsd_pkg::ST_NORM_LZ:
            begin
                lz_next = lz_out;
            end
            pfsd_pkg::ST_NORM:
            begin
                if (sum_reg[27])
                begin
                    mn = {sum_reg[27:2], (sum_reg[1] | sum_reg[0])};
                    e1 = exp_reg + 9'd1;
                end
                else
                begin
                    lim = (exp_reg - 9'd1 > 9'd63) ? 6'd63 : 6'(exp_reg - 9'd1);
                    sh  = (lz_reg < lim) ? lz_reg : lim;
                    mn  = sum_reg[26:0] << sh;
                    e1  = exp_reg - 9'(sh);
                end
                inc = mn[2] & (mn[1] | mn[0] | mn[3]);
                k   = {1'b0, mn[26:3]} + 25'(inc);
                if (k[24])
                begin
                    km = k[24:1];
                    e1 = e1 + 9'd1;
                end
                else
                begin
                    km = k[23:0];
                end
                if (spec_reg)
                begin
                    out_next.value_bits = spec_bits_reg;
                end
                else if (e1 >= 9'd255)
                begin
                    out_next.value_bits = {sign_reg, 8'hFF, 23'h0};
                end
                else if (km == '0)
                begin
                    out_next.value_bits = {(sub_reg ? 1'b0 : sign_reg), 31'h0};
                end
                else
                begin
                    out_next.value_bits = {sign_reg, (km[23] ? e1[7:0] : 8'h00), km[22:0]};
                end
                out_next.last_of_run = last_reg;
                out_next.record_done = done_reg;
            end
            pfsd_pkg::ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= 1'b0;
            cbits_reg  <= 6'd16;
            rexp_reg   <= '0;
            min_reg    <= '0;
            vcount_reg <= pfsd_pkg::COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (pfsd_pkg::cfg_idx_t'(cfg_index))
                pfsd_pkg::CFG_FORMAT_MODE:    fmt_reg    <= cfg_data[0];
                pfsd_pkg::CFG_CODE_BITS:      cbits_reg  <= cfg_data[5:0];
                pfsd_pkg::CFG_RANGE_EXPONENT: rexp_reg   <= $signed(cfg_data[8:0]);
                pfsd_pkg::CFG_MINIMUM_VALUE:  min_reg    <= cfg_data;
                pfsd_pkg::CFG_VALUE_COUNT:    vcount_reg <= cfg_data[pfsd_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfsd_pkg::ST_IDLE;
            store_reg <= '0;
            held_reg  <= '0;
            left_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            store_reg <= store_next;
            held_reg  <= held_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        last_reg      <= last_next;
        done_reg      <= done_next;
        lz_reg        <= lz_next;
        m_reg         <= m_next;
        p_reg         <= p_next;
        prod_reg      <= prod_next;
        spec_reg      <= spec_next;
        spec_bits_reg <= spec_bits_next;
        exp_reg       <= exp_next;
        sign_reg      <= sign_next;
        sub_reg       <= sub_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        sum_reg       <= sum_next;
        out_reg       <= out_next;
    end

endmodule

// File: hdl/pfsd_checker.sv
`include "packed_float_stream_decoder_top_macros.svh"

module pfsd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input pfsd_pkg::out_t out_data
);

    `PFSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data),
        "output beat changed while stalled")

    `PFSD_ASSERT_SAME(a_one_side, 1'b1, !(in_ready && out_valid),
        "input taken while a result is offered")

    `PFSD_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready,
        "input taken again right after a beat")

    `PFSD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !out_data.last_of_run,
        !in_ready, "new byte taken before the run of results ended")

endmodule

bind packed_float_stream_decoder_top pfsd_checker u_pfsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// File: tb/sv/pfsd_checker.sv
module pfsd_scoreboard (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  pfsd_pkg::in_t                   in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  pfsd_pkg::out_t                  out_data,
    input  logic                            cfg_write,
    input  logic [pfsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfsd_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              pending,
    output int                              failures
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                          raw_mode;
    logic [5:0]                    code_width;
    logic [8:0]                    scale_exp;
    logic [31:0]                   min_bits;
    logic [pfsd_pkg::COUNT_W-1:0]  record_len;

    logic [pfsd_pkg::STORE_W-1:0]  bit_buf;
    int                            buf_bits;
    logic [pfsd_pkg::COUNT_W-1:0]  remaining;

    int fail_count = 0;
    int pend_count = 0;

    pfsd_pkg::out_t expected_values[$];

    assign failures = fail_count;
    assign pending  = pend_count;

    // Rounds mag * 2^ex to single precision, nearest even.
    function automatic logic [31:0] fp_round(logic sgn, logic [63:0] mag, int ex);
        int           p;
        int           shift;
        int           biased;
        logic [127:0] wide;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] half;
        if (mag == 64'd0)
            return {sgn, 31'd0};
        p = 63;
        while (!mag[p])
            p--;
        if (p + ex > 127)
            return {sgn, 8'hFF, 23'd0};
        if (p + ex >= -126)
        begin
            shift  = p - 23;
            biased = p + ex + 126;
        end
        else
        begin
            shift  = -149 - ex;
            biased = 0;
        end
        wide = {64'd0, mag};
        if (shift <= 0)
            q = wide << (-shift);
        else if (shift > 100)
            q = 128'd0;
        else
        begin
            q    = wide >> shift;
            rem  = wide & ((128'd1 << shift) - 128'd1);
            half = 128'd1 << (shift - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 128'd1;
        end
        return {sgn, 31'd0} + 32'(biased) * 32'h0080_0000 + q[31:0];
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] sum;
        int          xa;
        int          xb;
        int          d;
        logic        sgn;
        if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
            return pfsd_pkg::QNAN_BITS;
        if (a[30:23] == 8'hFF)
            return (b[30:23] == 8'hFF && a[31] != b[31]) ? pfsd_pkg::QNAN_BITS : a;
        if (b[30:23] == 8'hFF)
            return b;
        if (b[30:23] > a[30:23])
        begin
            t = a;
            a = b;
            b = t;
        end
        ma = (a[30:23] == 0) ? {41'd0, a[22:0]} : {40'd0, 1'b1, a[22:0]};
        mb = (b[30:23] == 0) ? {41'd0, b[22:0]} : {40'd0, 1'b1, b[22:0]};
        xa = (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
        xb = (b[30:23] == 0) ? -149 : int'(b[30:23]) - 150;
        if (ma == 0 && mb == 0)
            return {a[31] & b[31], 31'd0};
        if (mb == 0)
            return a;
        if (ma == 0)
            return b;
        d  = xa - xb;
        ma = ma << 38;
        mb = mb << 38;
        if (d >= 64)
            mb = 64'd1;
        else if (d > 0)
            mb = (mb >> d) | 64'(|(mb & ((64'd1 << d) - 64'd1)));
        if (a[31] == b[31])
        begin
            sum = ma + mb;
            sgn = a[31];
        end
        else if (ma > mb)
        begin
            sum = ma - mb;
            sgn = a[31];
        end
        else if (mb > ma)
        begin
            sum = mb - ma;
            sgn = b[31];
        end
        else
            return 32'd0;
        return fp_round(sgn, sum, xa - 38);
    endfunction

    function automatic logic [31:0] scaled_value(logic [31:0] code);
        int          e;
        logic [31:0] cf;
        logic [31:0] prod;
        logic [31:0] r;
        e  = int'($signed(scale_exp));
        cf = fp_round(1'b0, {32'd0, code}, 0);
        if (code == 0)
        begin
            if (e > 127)
                return pfsd_pkg::QNAN_BITS;
            prod = 32'd0;
        end
        else if (e > 127)
            prod = 32'h7F80_0000;
        else if (e < -149)
            prod = 32'd0;
        else
            prod = fp_round(1'b0, {40'd0, 1'b1, cf[22:0]}, int'(cf[30:23]) - 150 + e);
        r = fp_add(prod, min_bits);
        if (r[30:23] == 8'hFF && r[22:0] != 0)
            r = pfsd_pkg::QNAN_BITS;
        return r;
    endfunction

    task automatic take_byte(pfsd_pkg::in_t beat);
        int             width;
        int             made;
        logic [31:0]    code;
        pfsd_pkg::out_t res;
        made = 0;
        if (beat.first_of_record)
        begin
            bit_buf   = '0;
            buf_bits  = 0;
            remaining = record_len;
        end
        if (remaining == 0)
        begin
            bit_buf  = '0;
            buf_bits = 0;
            return;
        end
        bit_buf  = {bit_buf[pfsd_pkg::STORE_W-9:0], beat.data_byte};
        buf_bits = buf_bits + 8;
        if (raw_mode)
            width = 32;
        else if (code_width < 1)
            width = 1;
        else if (code_width > pfsd_pkg::MAX_CODE_BITS)
            width = pfsd_pkg::MAX_CODE_BITS;
        else
            width = code_width;
        while (made < pfsd_pkg::STEP_RESULTS && remaining != 0 && buf_bits >= width)
        begin
            buf_bits  = buf_bits - width;
            code      = 32'((bit_buf >> buf_bits) & ((40'd1 << width) - 40'd1));
            bit_buf   = bit_buf & ((40'd1 << buf_bits) - 40'd1);
            remaining = remaining - 1'b1;
            res.value_bits  = raw_mode ? code : scaled_value(code);
            res.last_of_run = 1'b0;
            res.record_done = (remaining == 0);
            expected_values.push_back(res);
            made++;
        end
        if (remaining == 0)
        begin
            bit_buf  = '0;
            buf_bits = 0;
        end
        if (made > 0)
            expected_values[expected_values.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        pfsd_pkg::out_t want;
        if (!rst_n)
        begin
            raw_mode   = 1'b0;
            code_width = 6'd16;
            scale_exp  = 9'd0;
            min_bits   = 32'd0;
            record_len = pfsd_pkg::COUNT_W'(1);
            bit_buf    = '0;
            buf_bits   = 0;
            remaining  = '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (pfsd_pkg::cfg_idx_t'(cfg_index))
                    pfsd_pkg::CFG_FORMAT_MODE:    raw_mode   = cfg_data[0];
                    pfsd_pkg::CFG_CODE_BITS:      code_width = cfg_data[5:0];
                    pfsd_pkg::CFG_RANGE_EXPONENT: scale_exp  = cfg_data[8:0];
                    pfsd_pkg::CFG_MINIMUM_VALUE:  min_bits   = cfg_data;
                    pfsd_pkg::CFG_VALUE_COUNT:
                        record_len = cfg_data[pfsd_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                take_byte(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                    report_mismatch("unexpected beat", out_data.value_bits, 32'd0);
                else
                begin
                    want = expected_values.pop_front();
                    if (out_data.value_bits !== want.value_bits)
                        report_mismatch("value_bits", out_data.value_bits, want.value_bits);
                    if (out_data.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(out_data.last_of_run),
                                        32'(want.last_of_run));
                    if (out_data.record_done !== want.record_done)
                        report_mismatch("record_done", 32'(out_data.record_done),
                                        32'(want.record_done));
                end
            end
        end
        pend_count = expected_values.size();
    end

endmodule

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 290;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 80;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    pfsd_pkg::in_t                   in_data   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    pfsd_pkg::out_t                  out_data;
    logic                            cfg_write = 1'b0;
    logic [pfsd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pfsd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    int                              pending;
    int                              failures;

    int   idle_cycles = 0;
    int   burst_left  = 0;
    logic steady      = 1'b0;
    int   stall_left  = 0;
    int   stall_mode  = 0;
    int   stall_tick  = 0;
    int   bytes_sent  = 0;

    logic       cur_raw;
    logic [5:0] cur_width;
    int         cur_count;

    packed_float_stream_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pfsd_scoreboard u_scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (stall_tick % 5 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic first);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
            steady     = ($urandom_range(0, 3) == 0);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, first_of_record: first};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(pfsd_pkg::cfg_idx_t idx, logic [31:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            pfsd_pkg::CFG_FORMAT_MODE: cur_raw   = v[0];
            pfsd_pkg::CFG_CODE_BITS:   cur_width = v[5:0];
            pfsd_pkg::CFG_VALUE_COUNT: cur_count = int'(v[pfsd_pkg::COUNT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic set_all(logic raw, logic [5:0] width, int e, logic [31:0] mn, int cnt);
        write_reg(pfsd_pkg::CFG_FORMAT_MODE, {31'd0, raw});
        write_reg(pfsd_pkg::CFG_CODE_BITS, {26'd0, width});
        write_reg(pfsd_pkg::CFG_RANGE_EXPONENT, {23'd0, 9'(e)});
        write_reg(pfsd_pkg::CFG_MINIMUM_VALUE, mn);
        write_reg(pfsd_pkg::CFG_VALUE_COUNT, 32'(cnt));
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_record(int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_byte(random_byte(), i == 0);
    endtask

    initial
    begin
        int width;
        int nbytes;
        int budget;
        int e;
        logic [31:0] mn;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        cur_raw   = 1'b0;
        cur_width = 6'd16;
        cur_count = 1;

        send_byte(8'h5A, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        wait_idle();
        write_reg(pfsd_pkg::CFG_VALUE_COUNT, 32'd0);
        send_byte(8'h3C, 1'b1);
        wait_idle();
        set_all(1'b0, 6'd0, -256, 32'hFF80_0000, 8);
        send_byte(8'hA5, 1'b1);
        wait_idle();
        set_all(1'b0, 6'd8, 255, 32'd0, 2);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        wait_idle();
        set_all(1'b0, 6'd63, -149, 32'h3F80_0000, 1);
        send_byte(8'hFF, 1'b1);
        repeat (3) send_byte(8'hFF, 1'b0);
        wait_idle();
        set_all(1'b0, 6'd5, -140, 32'h8000_0000, 3);
        send_byte(8'h9D, 1'b1);
        send_byte(8'h6B, 1'b0);
        wait_idle();
        set_all(1'b0, 6'd4, 0, 32'h7FA0_0000, 2);
        send_byte(8'h1F, 1'b1);
        wait_idle();
        set_all(1'b1, 6'd7, 0, 32'd0, 1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hEE, 1'b0);
        wait_idle();
        set_all(1'b0, 6'd32, 0, 32'd0, 20);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h81, 1'b0);
        send_byte(8'h7E, 1'b0);
        wait_idle();
        write_reg(pfsd_pkg::CFG_CODE_BITS, 32'd1);
        send_byte(8'h96, 1'b0);
        send_byte(8'h0F, 1'b0);
        wait_idle();
        write_reg(pfsd_pkg::CFG_VALUE_COUNT, 32'h000F_FFFF);
        send_byte(8'h69, 1'b1);
        wait_idle();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       width = $urandom_range(33, 63);
                1:       width = 0;
                2:       width = 32;
                default: width = $urandom_range(1, 32);
            endcase
            case ($urandom_range(0, 5))
                0:       e = $urandom_range(0, 511) - 256;
                1:       e = ($urandom_range(0, 1) != 0) ? 255 : -256;
                2:       e = -150 + $urandom_range(0, 30);
                default: e = $urandom_range(0, 60) - 30;
            endcase
            case ($urandom_range(0, 5))
                0:       mn = 32'd0;
                1:       mn = 32'hFFFF_FFFF;
                2:       mn = {$urandom_range(0, 1) != 0, 8'hFF, 23'(($urandom_range(0, 1)
                              != 0) ? $urandom : 0)};
                3:       mn = {1'b1, 8'(127 + $urandom_range(0, 20)), 23'($urandom)};
                default: mn = $urandom;
            endcase
            case ($urandom_range(0, 19))
                0, 1:    budget = 0;
                2, 3, 4: budget = $urandom_range(5, 12);
                default: budget = $urandom_range(1, 4);
            endcase
            set_all($urandom_range(0, 3) == 0, 6'(width), e, mn, budget);
            width  = cur_raw ? 32 : (cur_width == 0 ? 1 : (cur_width > 32 ? 32 : cur_width));
            budget = bytes_sent + $urandom_range(20, 35);
            while (bytes_sent < budget)
            begin
                nbytes = (cur_count * width + 7) / 8;
                case ($urandom_range(0, 19))
                    0, 1, 2: nbytes = nbytes + $urandom_range(1, 3);
                    3, 4:    nbytes = $urandom_range(1, nbytes + 1);
                    default: ;
                endcase
                if (nbytes < 1)
                    nbytes = 1;
                send_record(nbytes);
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 2)) send_byte(random_byte(), 1'b0);
            end
        end

        wait_idle();
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
